### rtl/gds_pkg.sv
// ============================================================================
// gds_pkg: shared definitions for the grid diffusion stencil unit
// Grid geometry, field widths, request opcodes, register indexes and the
// controller state type used by the stencil unit and its storage.
// ============================================================================
`default_nettype none

package gds_pkg;

	// Grid geometry. Both dimensions may range from 2 to 256.
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;

	// Address widths for a column and a row within the stored grid.
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;
	localparam int GRID_DEPTH = 1 << AW;

	// Counter widths that can also hold the full dimension.
	localparam int CNT_CW = $clog2(MAX_COLUMNS + 1);
	localparam int CNT_RW = $clog2(MAX_ROWS + 1);

	// Field widths fixed by the interface.
	localparam int CELL_W     = 17;
	localparam int DIM_W      = 9;
	localparam int COORD_W    = 8;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// 1.0 in the 16-bit fraction fixed point format.
	localparam logic [CELL_W-1:0] ONE_FIXED = CELL_W'(65536);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_THR   = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_DIFFUSE = 3'd0,
		OP_DEPOSIT = 3'd1,
		OP_READ    = 3'd2,
		OP_PRUNE   = 3'd3,
		OP_CLEAR   = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DEPOSIT,
		ST_READ,
		ST_LOAD,
		ST_LOAD_END,
		ST_ROW,
		ST_ROW_END,
		ST_PRUNE,
		ST_PRUNE_END,
		ST_CLEAR,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

### rtl/gds_ram.sv
// ============================================================================
// gds_ram: generic simple dual port memory
// One write port and one read port with a registered read; the read data
// holds its value while no read is requested.
// ============================================================================
`default_nettype none

module gds_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire              clk,
	input  wire              wr_en,
	input  wire [AW-1:0]     wr_addr,
	input  wire [WIDTH-1:0]  wr_data,
	input  wire              rd_en,
	input  wire [AW-1:0]     rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/grid_diffusion_stencil_unit.sv
// ============================================================================
// grid_diffusion_stencil_unit: five point diffusion over a scent grid
// Holds a grid of unsigned fixed point intensities (1.0 = 65536) and runs
// diffuse, deposit, read, prune and clear requests against it.
// ============================================================================
//
// Usage
// -----
// Requests arrive on the input channel (in_valid / in_stall) with an opcode
// and a cell coordinate. Every request gives exactly one response on the
// output channel (out_valid / out_stall): the cell value for a read, zero
// otherwise, and a flag when a deposit or read lies outside the active size.
// The configuration channel (cfg_valid / cfg_ready) sets the active width,
// height and prune threshold; it should only be written while the unit is
// idle.
// One request is handled at a time and the input stalls meanwhile. A deposit
// or read has a state of its own before the response; a diffuse loads the
// first row into a line buffer and sweeps row by row, a prune sweeps every
// active cell and a clear the whole grid, as the single grid memory serves
// one cell per cycle. A spare opcode or a pass over an empty area goes
// straight to the response. The input opens again in the same cycle as the
// response rises. After reset the same sweep zeroes the grid: the input
// stalls until each cell is written; configuration writes are still taken.
// A finished response waits in an output register while the receiver
// stalls; the unit then holds the next response until that one is taken.
`default_nettype none

module grid_diffusion_stencil_unit
	import gds_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [OP_W-1:0]        opcode,
	input  wire [COORD_W-1:0]     x_coord,
	input  wire [COORD_W-1:0]     y_coord,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [CELL_W-1:0]     cell_value,
	output logic                  out_of_range
);

	localparam int SUM_W = CELL_W + 1;

	// New cell value: floor(3c/8) plus one eighth of each neighbour that
	// lies in the active area. Neighbours outside it arrive as zero.
	function automatic logic [CELL_W-1:0] stencil_sum(
		input logic [CELL_W-1:0] c,
		input logic [CELL_W-1:0] l,
		input logic [CELL_W-1:0] r,
		input logic [CELL_W-1:0] u,
		input logic [CELL_W-1:0] d
	);
		logic [CELL_W+1:0] three_c;
		logic [SUM_W-1:0]  sum;
		three_c = {2'b00, c} + {1'b0, c, 1'b0};
		sum = SUM_W'(three_c >> 3) + SUM_W'(l >> 3) + SUM_W'(r >> 3)
			+ SUM_W'(u >> 3) + SUM_W'(d >> 3);
		return sum[CELL_W] ? '1 : sum[CELL_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [DIM_W-1:0]  grid_width_q;
	logic [DIM_W-1:0]  grid_height_q;
	logic [CELL_W-1:0] prune_thr_q;

	logic [CNT_CW-1:0] act_cols;
	logic [CNT_RW-1:0] act_rows;
	logic              grid_empty;
	logic              in_accept;
	logic              in_area;

	opcode_t           op_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic              in_area_q;
	logic              flag_q;

	logic [CNT_CW-1:0] col_q;
	logic [CNT_RW-1:0] row_q;
	logic [AW-1:0]     clr_addr_q;
	logic              col_last;
	logic              row_last;

	// Roles of the three line buffers: old row above, old current row and
	// the old row below, which is captured while the current row is written.
	logic [1:0]        prev_sel_q;
	logic [1:0]        cur_sel_q;
	logic [1:0]        next_sel_q;

	state_t            st_s1;
	logic [CNT_CW-1:0] col_s1;
	logic [AW-1:0]     addr_s1;

	logic [CELL_W-1:0] win_l_q;
	logic [CELL_W-1:0] win_c_q;
	logic [CELL_W-1:0] up_q;
	logic [CELL_W-1:0] down_q;

	logic              grid_we;
	logic              grid_re;
	logic [AW-1:0]     grid_wa;
	logic [AW-1:0]     grid_ra;
	logic [CELL_W-1:0] grid_wd;
	logic [CELL_W-1:0] grid_rd;

	logic              lb_wr;
	logic [1:0]        lb_wsel;
	logic [2:0]        lb_we;
	logic              lb_re;
	logic [CW-1:0]     lb_wa;
	logic [CW-1:0]     lb_ra;
	logic [CELL_W-1:0] lb_wd;
	logic [CELL_W-1:0] lb_rd [3];

	logic [CELL_W-1:0] cur_rd;
	logic [CELL_W-1:0] prev_rd;
	logic              s1_has_right;
	logic              s1_has_cell;
	logic [CELL_W-1:0] s1_left;
	logic [CELL_W-1:0] s1_right;
	logic [CELL_W-1:0] s1_up;
	logic [CELL_W-1:0] s1_down;
	logic [CELL_W-1:0] new_val;

	logic              out_valid_q;
	logic [CELL_W-1:0] cell_value_q;
	logic              out_of_range_q;

	// ------------------------------------------------------------------
	// Active size and request acceptance
	// ------------------------------------------------------------------
	// A dimension larger than the stored grid acts as the stored size.
	always_comb begin
		act_cols = (32'(grid_width_q) > MAX_COLUMNS) ? CNT_CW'(MAX_COLUMNS)
			: CNT_CW'(grid_width_q);
		act_rows = (32'(grid_height_q) > MAX_ROWS) ? CNT_RW'(MAX_ROWS)
			: CNT_RW'(grid_height_q);
	end

	assign grid_empty = (act_cols == '0) || (act_rows == '0);
	assign in_area    = (32'(x_coord) < 32'(act_cols)) && (32'(y_coord) < 32'(act_rows));
	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;

	assign col_last = ((col_q + 1'b1) == act_cols);
	assign row_last = ((row_q + 1'b1) == act_rows);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (clr_addr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept) begin
					case (opcode_t'(opcode))
						OP_DIFFUSE: state_d = grid_empty ? ST_RESP : ST_LOAD;
						OP_DEPOSIT: state_d = ST_DEPOSIT;
						OP_READ:    state_d = ST_READ;
						OP_PRUNE:   state_d = grid_empty ? ST_RESP : ST_PRUNE;
						OP_CLEAR:   state_d = ST_CLEAR;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_DEPOSIT:   state_d = ST_RESP;
			ST_READ:      state_d = ST_RESP;
			ST_LOAD: begin
				if (col_last) state_d = ST_LOAD_END;
			end
			ST_LOAD_END:  state_d = ST_ROW;
			ST_ROW: begin
				if (col_q == act_cols) state_d = ST_ROW_END;
			end
			ST_ROW_END:   state_d = row_last ? ST_RESP : ST_ROW;
			ST_PRUNE: begin
				if (col_last && row_last) state_d = ST_PRUNE_END;
			end
			ST_PRUNE_END: state_d = ST_RESP;
			ST_CLEAR: begin
				if (clr_addr_q == '1) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Stencil datapath in the stage after the memory reads
	// ------------------------------------------------------------------
	// An entry of the window at column k completes the cell at k-1, so the
	// right neighbour is the line buffer word that has just arrived.
	assign cur_rd       = lb_rd[cur_sel_q];
	assign prev_rd      = lb_rd[prev_sel_q];
	assign s1_has_right = (col_s1 < act_cols);
	assign s1_has_cell  = (col_s1 != '0);
	assign s1_left      = (col_s1 > CNT_CW'(1)) ? win_l_q : '0;
	assign s1_right     = s1_has_right ? cur_rd : '0;
	assign s1_up        = (row_q != '0) ? up_q : '0;
	assign s1_down      = row_last ? '0 : down_q;
	assign new_val      = stencil_sum(win_c_q, s1_left, s1_right, s1_up, s1_down);

	// ------------------------------------------------------------------
	// Memory control
	// ------------------------------------------------------------------
	always_comb begin
		grid_we = 1'b0;
		grid_re = 1'b0;
		grid_wa = '0;
		grid_ra = '0;
		grid_wd = '0;
		lb_wr   = 1'b0;
		lb_wsel = cur_sel_q;
		lb_re   = 1'b0;
		lb_wa   = '0;
		lb_ra   = '0;
		lb_wd   = grid_rd;

		// Issue side, driven by the current state.
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				grid_we = 1'b1;
				grid_wa = clr_addr_q;
			end
			ST_DEPOSIT: begin
				grid_we = in_area_q;
				grid_wa = {RW'(y_q), CW'(x_q)};
				grid_wd = ONE_FIXED;
			end
			ST_READ: begin
				grid_re = 1'b1;
				grid_ra = {RW'(y_q), CW'(x_q)};
			end
			ST_LOAD: begin
				grid_re = 1'b1;
				grid_ra = {{RW{1'b0}}, CW'(col_q)};
			end
			ST_ROW: begin
				if (col_q != act_cols) begin
					grid_re = 1'b1;
					lb_re   = 1'b1;
				end
				grid_ra = {RW'(row_q + 1'b1), CW'(col_q)};
				lb_ra   = CW'(col_q);
			end
			ST_PRUNE: begin
				grid_re = 1'b1;
				grid_ra = {RW'(row_q), CW'(col_q)};
			end
			default: ;
		endcase

		// Write-back side, in the cycle after the reads are issued.
		case (st_s1)
			ST_LOAD: begin
				lb_wr   = 1'b1;
				lb_wsel = cur_sel_q;
				lb_wa   = CW'(col_s1);
			end
			ST_ROW: begin
				lb_wr   = s1_has_right;
				lb_wsel = next_sel_q;
				lb_wa   = CW'(col_s1);
				grid_we = s1_has_cell;
				grid_wa = {RW'(row_q), CW'(col_s1 - 1'b1)};
				grid_wd = new_val;
			end
			ST_PRUNE: begin
				grid_we = (grid_rd <= prune_thr_q);
				grid_wa = addr_s1;
				grid_wd = '0;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			st_s1         <= ST_IDLE;
			clr_addr_q    <= '0;
			col_q         <= '0;
			row_q         <= '0;
			prev_sel_q    <= 2'd0;
			cur_sel_q     <= 2'd1;
			next_sel_q    <= 2'd2;
			out_valid_q   <= 1'b0;
			grid_width_q  <= DIM_W'(256);
			grid_height_q <= DIM_W'(256);
			prune_thr_q   <= '0;
		end else begin
			state_q <= state_d;
			st_s1   <= state_q;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
					CFG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
					CFG_PRUNE_THR:   prune_thr_q   <= cfg_data[CELL_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						col_q      <= '0;
						row_q      <= '0;
						clr_addr_q <= '0;
					end
				end
				ST_INIT, ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_LOAD: begin
					col_q <= col_last ? '0 : col_q + 1'b1;
				end
				ST_ROW: begin
					col_q <= col_q + 1'b1;
				end
				ST_ROW_END: begin
					// The old current row becomes the row above, the row
					// captured below becomes current.
					col_q      <= '0;
					row_q      <= row_q + 1'b1;
					prev_sel_q <= cur_sel_q;
					cur_sel_q  <= next_sel_q;
					next_sel_q <= prev_sel_q;
				end
				ST_PRUNE: begin
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase

			if (state_q == ST_RESP && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= opcode_t'(opcode);
			x_q       <= x_coord;
			y_q       <= y_coord;
			in_area_q <= in_area;
			flag_q    <= ((opcode_t'(opcode) == OP_DEPOSIT) || (opcode_t'(opcode) == OP_READ))
				&& !in_area;
		end

		col_s1  <= col_q;
		addr_s1 <= grid_ra;

		if (st_s1 == ST_ROW && s1_has_right) begin
			win_l_q <= win_c_q;
			win_c_q <= cur_rd;
			up_q    <= prev_rd;
			down_q  <= grid_rd;
		end

		if (state_q == ST_RESP && state_d == ST_IDLE) begin
			cell_value_q   <= (op_q == OP_READ && in_area_q) ? grid_rd : '0;
			out_of_range_q <= flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_value   = cell_value_q;
	assign out_of_range = out_of_range_q;

	// ------------------------------------------------------------------
	// Storage
	// ------------------------------------------------------------------
	gds_ram #(
		.WIDTH (CELL_W),
		.DEPTH (GRID_DEPTH)
	) u_grid_ram (
		.clk     (clk),
		.wr_en   (grid_we),
		.wr_addr (grid_wa),
		.wr_data (grid_wd),
		.rd_en   (grid_re),
		.rd_addr (grid_ra),
		.rd_data (grid_rd)
	);

	for (genvar i = 0; i < 3; i++) begin : g_line_buf
		assign lb_we[i] = lb_wr && (lb_wsel == 2'(i));

		gds_ram #(
			.WIDTH (CELL_W),
			.DEPTH (MAX_COLUMNS)
		) u_line_ram (
			.clk     (clk),
			.wr_en   (lb_we[i]),
			.wr_addr (lb_wa),
			.wr_data (lb_wd),
			.rd_en   (lb_re),
			.rd_addr (lb_ra),
			.rd_data (lb_rd[i])
		);
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The three line buffers must always play three different roles.
	a_roles_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_sel_q != cur_sel_q) && (cur_sel_q != next_sel_q) && (prev_sel_q != next_sel_q))
		else $error("line buffer roles overlap");

	// A write-back never lands on the cell being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(grid_we && grid_re) |-> (grid_wa != grid_ra))
		else $error("grid read and write at the same address");

	// A new response waits while the previous one is still stalled.
	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_valid_q && out_stall) |=> (state_q == ST_RESP))
		else $error("response overwritten while stalled");

	// A response only appears on leaving the response state.
	a_resp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("response raised outside the response state");

endmodule

`default_nettype wire
